[rtl/ghpc_pkg.sv]
// Shared types and constants for the hint pair compatibility block.
`default_nettype none
package ghpc_pkg;
	localparam logic [4:0] K_START      = 5'd0;
	localparam logic [4:0] K_STOP       = 5'd1;
	localparam logic [4:0] K_ASS        = 5'd2;
	localparam logic [4:0] K_DSS        = 5'd3;
	localparam logic [4:0] K_TSS        = 5'd4;
	localparam logic [4:0] K_TTS        = 5'd5;
	localparam logic [4:0] K_EXONPART   = 5'd6;
	localparam logic [4:0] K_EXON       = 5'd7;
	localparam logic [4:0] K_INTRONPART = 5'd8;
	localparam logic [4:0] K_INTRON     = 5'd9;
	localparam logic [4:0] K_IRPART     = 5'd10;
	localparam logic [4:0] K_CDS        = 5'd11;
	localparam logic [4:0] K_CDSPART    = 5'd12;
	localparam logic [4:0] K_UTR        = 5'd13;
	localparam logic [4:0] K_UTRPART    = 5'd14;
	localparam logic [4:0] K_NONEXONPART = 5'd15;
	localparam logic [4:0] K_GENICPART  = 5'd16;
	localparam logic [1:0] S_PLUS  = 2'd0;
	localparam logic [1:0] S_MINUS = 2'd1;
	localparam logic [2:0] REG_TSS_CLOSE = 3'd0;
	localparam logic [2:0] REG_TTS_CLOSE = 3'd1;
	localparam logic [2:0] REG_MARGIN    = 3'd2;
	localparam logic [15:0] TSS_CLOSE_RST = 16'd0;
	localparam logic [15:0] TTS_CLOSE_RST = 16'd1000;
	localparam logic [15:0] MARGIN_RST    = 16'd50;
	localparam logic signed [33:0] CDS_MIN_OVERLAP = 34'sd2;

	typedef struct packed {
		logic [4:0] kind;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [1:0] strand;
	} hint_t;

	// Compare results produced in stage 1, consumed in stage 2.
	typedef struct packed {
		logic [4:0]  ka, kb, k1, k2;
		logic [1:0]  sa, sb;
		logic        apart;      // intervals do not overlap
		logic        tss_close;
		logic        tts_close;
		logic        a_lo_lt_b_lo, a_lo_gt_b_lo, a_hi_lt_b_hi, a_hi_gt_b_hi;
		logic        f1_hi_lt_f2_lo2;   // f1.hi < f2.lo + 2
		logic        f1_lo_gt_f2_hi2;   // f1.lo > f2.hi - 2
		logic        f1_lo_gt_f2_lom;   // f1.lo > f2.lo + m
		logic        f1_hi_lt_f2_him;   // f1.hi < f2.hi - m
		logic        f1_lo_le_f2_hi;
	} cmp_t;

	typedef struct packed {
		logic compatible;
		logic a_weaker;
		logic strictly_weaker;
	} res_t;
endpackage
`default_nettype wire

[rtl/ghpc_cmp.sv]
// Stage 1: coordinate sums and magnitude compares.
`default_nettype none
module ghpc_cmp import ghpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire hint_t       a,
	input  wire hint_t       b,
	input  wire logic [15:0] tss_close,
	input  wire logic [15:0] tts_close,
	input  wire logic [15:0] margin,
	output cmp_t             cmp_s1
);
	logic swap;
	hint_t f1, f2;
	logic signed [33:0] d, ad, m;
	cmp_t c;

	always_comb begin
		swap = a.kind > b.kind;
		f1 = swap ? b : a;
		f2 = swap ? a : b;
		m  = $signed({18'd0, margin});
		d  = (34'(a.hi) + 34'(a.lo)) - (34'(b.hi) + 34'(b.lo));
		ad = d[33] ? -d : d;
		c.ka = a.kind;  c.kb = b.kind;
		c.k1 = f1.kind; c.k2 = f2.kind;
		c.sa = a.strand; c.sb = b.strand;
		c.apart = (a.lo > b.hi) || (a.hi < b.lo);
		c.tss_close = ad[33:1] <= 33'(tss_close);
		c.tts_close = ad[33:1] <= 33'(tts_close);
		c.a_lo_lt_b_lo = a.lo < b.lo;
		c.a_lo_gt_b_lo = a.lo > b.lo;
		c.a_hi_lt_b_hi = a.hi < b.hi;
		c.a_hi_gt_b_hi = a.hi > b.hi;
		c.f1_hi_lt_f2_lo2 = 34'(f1.hi) < 34'(f2.lo) + CDS_MIN_OVERLAP;
		c.f1_lo_gt_f2_hi2 = 34'(f1.lo) > 34'(f2.hi) - CDS_MIN_OVERLAP;
		c.f1_lo_gt_f2_lom = 34'(f1.lo) > 34'(f2.lo) + m;
		c.f1_hi_lt_f2_him = 34'(f1.hi) < 34'(f2.hi) - m;
		c.f1_lo_le_f2_hi  = f1.lo <= f2.hi;
	end

	always_ff @(posedge clk) begin
		if (en) cmp_s1 <= c;
	end
endmodule
`default_nettype wire

[rtl/ghpc_rule.sv]
// Stage 2: kind and strand rule tables.
`default_nettype none
module ghpc_rule import ghpc_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire cmp_t c,
	output res_t      res_s2
);
	logic swap, lo_lt, lo_gt, hi_lt, hi_gt, f_lo_gt, f_lo_lt, f_hi_lt, f_hi_gt;
	logic f_in, a_in, same_iv, comp, w, st, opp;
	logic [4:0] k1, k2, ka, kb;
	logic [1:0] s;

	always_comb begin
		ka = c.ka; kb = c.kb; k1 = c.k1; k2 = c.k2; s = c.sa;
		swap = ka > kb;
		lo_lt = c.a_lo_lt_b_lo; lo_gt = c.a_lo_gt_b_lo;
		hi_lt = c.a_hi_lt_b_hi; hi_gt = c.a_hi_gt_b_hi;
		// f1 relative to f2
		f_lo_gt = swap ? lo_lt : lo_gt;
		f_lo_lt = swap ? lo_gt : lo_lt;
		f_hi_lt = swap ? hi_gt : hi_lt;
		f_hi_gt = swap ? hi_lt : hi_gt;
		f_in = !f_lo_lt && !f_hi_gt;
		a_in = !lo_lt && !hi_gt;
		same_iv = !lo_lt && !lo_gt && !hi_lt && !hi_gt;
		opp = (c.sa == S_MINUS && c.sb == S_PLUS) || (c.sa == S_PLUS && c.sb == S_MINUS);
		comp = 1'b0;
		if (c.apart) begin
			comp = !((ka == K_TSS && kb == K_TSS && c.sa == c.sb && c.tss_close) ||
				(ka == K_TTS && kb == K_TTS && c.sa == c.sb && c.tts_close));
		end else if (opp) begin
			comp = ((ka <= K_TTS) && (kb <= K_TTS)) ||
				((ka <= K_TTS) && (lo_lt || hi_gt)) ||
				((kb <= K_TTS) && (lo_gt || hi_lt));
		end else if (ka == kb) begin
			comp = same_iv || !(ka == K_EXON || ka == K_INTRON || ka == K_CDS ||
				ka == K_UTR);
		end else if (k1 == K_START || k1 == K_STOP) begin
			comp = 1'b1;
			if ((k2 == K_INTRONPART || k2 == K_INTRON || k2 == K_IRPART ||
				k2 == K_NONEXONPART || k2 == K_UTR || k2 == K_UTRPART) && f_in)
				comp = 1'b0;
			if (k2 == K_CDSPART || k2 == K_CDS) begin
				if (f_lo_gt && f_hi_lt) comp = 1'b0;
				if (s == S_PLUS && ((k1 == K_START && f_lo_gt) || (k1 == K_STOP && f_hi_lt)))
					comp = 1'b0;
				if (s == S_MINUS && ((k1 == K_START && f_hi_lt) || (k1 == K_STOP && f_lo_gt)))
					comp = 1'b0;
				if (k2 == K_CDS && (c.f1_hi_lt_f2_lo2 || c.f1_lo_gt_f2_hi2)) comp = 1'b0;
			end
		end else if (k1 == K_ASS || k1 == K_DSS) begin
			comp = 1'b1;
			if ((k2 == K_IRPART || k2 == K_UTR || k2 == K_UTRPART || k2 == K_EXONPART ||
				k2 == K_EXON || k2 == K_CDS || k2 == K_CDSPART) && f_in)
				comp = 1'b0;
			if (k2 == K_INTRON || k2 == K_INTRONPART) begin
				if (f_lo_gt && f_hi_lt) comp = 1'b0;
				if (s == S_PLUS && ((k1 == K_DSS && f_lo_gt) || (k1 == K_ASS && f_hi_lt)))
					comp = 1'b0;
				if (s == S_MINUS && ((k1 == K_DSS && f_hi_lt) || (k1 == K_ASS && f_lo_gt)))
					comp = 1'b0;
			end
		end else if (k1 == K_TSS || k1 == K_TTS) begin
			comp = 1'b1;
			if ((k2 == K_IRPART || k2 == K_INTRON || k2 == K_INTRONPART ||
				k2 == K_NONEXONPART || k2 == K_CDS || k2 == K_CDSPART) && f_in)
				comp = 1'b0;
			if (k2 == K_UTR || k2 == K_UTRPART || k2 == K_EXON || k2 == K_EXONPART) begin
				if (c.f1_lo_gt_f2_lom && c.f1_hi_lt_f2_him) comp = 1'b0;
				if (s == S_PLUS && ((k1 == K_TSS && c.f1_lo_gt_f2_lom) ||
					(k1 == K_TTS && c.f1_hi_lt_f2_him)))
					comp = 1'b0;
				if (s == S_MINUS && ((k1 == K_TSS && c.f1_hi_lt_f2_him) ||
					(k1 == K_TTS && c.f1_lo_gt_f2_lom)))
					comp = 1'b0;
			end
		end else if (k1 == K_EXONPART) begin
			comp = !(k2 == K_INTRONPART || k2 == K_INTRON || k2 == K_IRPART ||
				k2 == K_NONEXONPART || (k2 == K_EXON && (f_lo_lt || f_hi_gt)) ||
				(k2 == K_UTR && f_lo_lt && f_hi_gt));
		end else if (k1 == K_EXON) begin
			comp = !(k2 == K_INTRONPART || k2 == K_INTRON || k2 == K_IRPART ||
				k2 == K_NONEXONPART ||
				(k2 == K_CDS && !(!f_lo_gt && !f_hi_lt)) ||
				(k2 == K_CDSPART && (f_lo_gt || f_hi_lt)) ||
				(k2 == K_UTR && !((!f_lo_gt && !f_lo_lt && !f_hi_lt) ||
					(!f_hi_gt && !f_hi_lt && c.f1_lo_le_f2_hi))) ||
				(k2 == K_UTRPART && (f_lo_gt || f_hi_lt)));
		end else if (k1 == K_INTRONPART || k1 == K_INTRON) begin
			comp = !((k1 == K_INTRONPART && k2 == K_INTRON && (f_lo_lt || f_hi_gt)) ||
				k2 == K_IRPART || k2 == K_CDS || k2 == K_CDSPART ||
				k2 == K_UTR || k2 == K_UTRPART);
		end else if (k1 == K_IRPART) begin
			comp = k2 == K_NONEXONPART;
		end else if (k1 == K_CDS) begin
			comp = k2 == K_CDSPART && !f_lo_gt && !f_hi_lt;
		end else if (k1 == K_UTR) begin
			comp = k2 == K_UTRPART && !f_lo_gt && !f_hi_lt;
		end

		// weaker: a against b
		st = !same_iv;
		if (c.apart) begin
			w = 1'b0;
		end else if (ka == kb && same_iv) begin
			w = 1'b1;
		end else if (ka == kb && ka <= K_TTS && !lo_gt && !hi_lt) begin
			w = 1'b1;
		end else if (!a_in) begin
			w = 1'b0;
		end else begin
			w = (ka == K_EXONPART && (kb == K_EXON || kb == K_EXONPART)) ||
				(ka == K_INTRONPART && (kb == K_INTRON || kb == K_INTRONPART)) ||
				(ka == K_IRPART && kb == K_IRPART) ||
				(ka == K_CDSPART && (kb == K_CDS || kb == K_CDSPART)) ||
				(ka == K_UTRPART && (kb == K_UTR || kb == K_UTRPART)) ||
				(ka == K_NONEXONPART && kb == K_NONEXONPART) ||
				(ka == K_GENICPART && kb != K_IRPART);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.compatible <= comp;
			res_s2.a_weaker <= w;
			res_s2.strictly_weaker <= w && st && !(ka == kb && same_iv);
		end
	end
endmodule
`default_nettype wire

[rtl/gene_hint_pair_compatibility.sv]
// Top level of the hint pair compatibility block.
// Takes one pair of hints per transfer on s_axis and returns one three-bit
// verdict per pair on m_axis, in order. Throughput is one pair per clock while
// m_axis is not stalled. The stages are an input register, a compare stage that
// forms the 34-bit coordinate sums and margin compares, and a rule stage that
// applies the kind and strand tables. The last stage is the output register. All
// stages advance together when the output is free or empty, so a stall on m_axis
// holds every stage without loss; s_axis_tready is the advance enable.
// Registers: 0 tss close distance, 1 tts close distance, 2 transcript margin;
// write them only while no pair is in flight.
`default_nettype none
module gene_hint_pair_compatibility import ghpc_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// type_a[4:0], begin_a[36:5], finish_a[68:37], strand_a[70:69], type_b[75:71],
	// begin_b[107:76], finish_b[139:108], strand_b[141:140], zero pad to 144
	input  wire logic [143:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// compatible[0], a_weaker[1], strictly_weaker[2], zero pad to 8
	output logic [7:0]        m_axis_tdata
);
	logic [15:0] tss_q, tts_q, margin_q;
	logic v_s0, v_s1, v_s2, adv;
	hint_t a_s0, b_s0;
	cmp_t cmp_s1;
	res_t res_s2;

	// Advance all stages when the output stage is empty or being taken.
	assign adv = !v_s2 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tss_q <= TSS_CLOSE_RST;
			tts_q <= TTS_CLOSE_RST;
			margin_q <= MARGIN_RST;
		end else if (cfg_we) begin
			if (3'(cfg_index) == REG_TSS_CLOSE) tss_q <= cfg_data;
			if (3'(cfg_index) == REG_TTS_CLOSE) tts_q <= cfg_data;
			if (3'(cfg_index) == REG_MARGIN) margin_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0; v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else if (adv) begin
			v_s0 <= s_axis_tvalid; v_s1 <= v_s0; v_s2 <= v_s1;
		end
	end

	// Capture the pair.
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s0 <= {s_axis_tdata[4:0], s_axis_tdata[36:5], s_axis_tdata[68:37],
				s_axis_tdata[70:69]};
			b_s0 <= {s_axis_tdata[75:71], s_axis_tdata[107:76], s_axis_tdata[139:108],
				s_axis_tdata[141:140]};
		end
	end

	ghpc_cmp u_cmp (.clk(clk), .en(adv), .a(a_s0), .b(b_s0), .tss_close(tss_q),
		.tts_close(tts_q), .margin(margin_q), .cmp_s1(cmp_s1));

	ghpc_rule u_rule (.clk(clk), .en(adv), .c(cmp_s1), .res_s2(res_s2));

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata = {5'd0, res_s2.strictly_weaker, res_s2.a_weaker, res_s2.compatible};
endmodule
`default_nettype wire

[rtl/ghpc_checker.sv]
// Port-level checker for the hint pair compatibility block, with its bind.
`default_nettype none
module ghpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0)
		else $error("pad bits set");
	a_strict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
		else $error("strict without weaker");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("stalled with empty output");
endmodule

bind gene_hint_pair_compatibility ghpc_checker u_ghpc_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire

[verif/gene_hint_pair_compatibility_tb.sv]
// Testbench for the hint pair compatibility block: random and directed hint pairs checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module gene_hint_pair_compatibility_tb;
	import ghpc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	gene_hint_pair_compatibility dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of the three registers.
	logic [15:0] tss_dist, tts_dist, margin;

	logic [143:0] pending_pairs[$];
	res_t verdicts_due[$];
	int fails = 0;
	int quiet_cycles = 0;

	typedef struct {
		logic [4:0] kind;
		longint lo;
		longint hi;
		logic [1:0] strand;
	} pair_hint_t;

	function automatic void queue_pair(logic [143:0] p);
		pending_pairs = {pending_pairs, p};
	endfunction

	function automatic pair_hint_t unpack_hint(logic [70:0] v);
		pair_hint_t h;
		h.kind = v[4:0];
		h.lo = longint'($signed(v[36:5]));
		h.hi = longint'($signed(v[68:37]));
		h.strand = v[70:69];
		return h;
	endfunction

	function automatic bit is_sig(logic [4:0] k);
		return k <= K_TTS;
	endfunction

	function automatic bit inside_of(pair_hint_t x, pair_hint_t y);
		return x.lo >= y.lo && x.hi <= y.hi;
	endfunction

	function automatic bit near_pair(pair_hint_t a, pair_hint_t b, logic [15:0] lim);
		longint d;
		d = (a.hi + a.lo) - (b.hi + b.lo);
		if (d < 0) d = -d;
		return d / 2 <= longint'(lim);
	endfunction

	function automatic bit pair_compatible(pair_hint_t a, pair_hint_t b);
		pair_hint_t f1, f2;
		logic [1:0] s;
		longint m;
		logic [4:0] k1, k2;
		s = a.strand;
		m = longint'(margin);
		if (a.lo > b.hi || a.hi < b.lo) begin
			if (a.kind == K_TSS && b.kind == K_TSS && a.strand == b.strand &&
				near_pair(a, b, tss_dist)) return 0;
			if (a.kind == K_TTS && b.kind == K_TTS && a.strand == b.strand &&
				near_pair(a, b, tts_dist)) return 0;
			return 1;
		end
		if ((a.strand == S_MINUS && b.strand == S_PLUS) ||
			(a.strand == S_PLUS && b.strand == S_MINUS)) begin
			if (is_sig(a.kind) && is_sig(b.kind)) return 1;
			if (is_sig(a.kind) && (a.lo < b.lo || a.hi > b.hi)) return 1;
			if (is_sig(b.kind) && (a.lo > b.lo || a.hi < b.hi)) return 1;
			return 0;
		end
		if (a.kind == b.kind) begin
			if (a.lo == b.lo && a.hi == b.hi) return 1;
			return !(a.kind == K_EXON || a.kind == K_INTRON || a.kind == K_CDS ||
				a.kind == K_UTR);
		end
		if (a.kind > b.kind) begin
			f1 = b; f2 = a;
		end else begin
			f1 = a; f2 = b;
		end
		k1 = f1.kind;
		k2 = f2.kind;
		if (k1 == K_START || k1 == K_STOP) begin
			if ((k2 == K_INTRONPART || k2 == K_INTRON || k2 == K_IRPART ||
				k2 == K_NONEXONPART || k2 == K_UTR || k2 == K_UTRPART) &&
				inside_of(f1, f2)) return 0;
			if (k2 == K_CDSPART || k2 == K_CDS) begin
				if (f1.lo > f2.lo && f1.hi < f2.hi) return 0;
				if (s == S_PLUS && ((k1 == K_START && f1.lo > f2.lo) ||
					(k1 == K_STOP && f1.hi < f2.hi))) return 0;
				if (s == S_MINUS && ((k1 == K_START && f1.hi < f2.hi) ||
					(k1 == K_STOP && f1.lo > f2.lo))) return 0;
				if (k2 == K_CDS && (f1.hi < f2.lo + 2 || f1.lo > f2.hi - 2)) return 0;
			end
			return 1;
		end
		if (k1 == K_ASS || k1 == K_DSS) begin
			if ((k2 == K_IRPART || k2 == K_UTR || k2 == K_UTRPART || k2 == K_EXONPART ||
				k2 == K_EXON || k2 == K_CDS || k2 == K_CDSPART) && inside_of(f1, f2))
				return 0;
			if (k2 == K_INTRON || k2 == K_INTRONPART) begin
				if (f1.lo > f2.lo && f1.hi < f2.hi) return 0;
				if (s == S_PLUS && ((k1 == K_DSS && f1.lo > f2.lo) ||
					(k1 == K_ASS && f1.hi < f2.hi))) return 0;
				if (s == S_MINUS && ((k1 == K_DSS && f1.hi < f2.hi) ||
					(k1 == K_ASS && f1.lo > f2.lo))) return 0;
			end
			return 1;
		end
		if (k1 == K_TSS || k1 == K_TTS) begin
			if ((k2 == K_IRPART || k2 == K_INTRON || k2 == K_INTRONPART ||
				k2 == K_NONEXONPART || k2 == K_CDS || k2 == K_CDSPART) &&
				inside_of(f1, f2)) return 0;
			if (k2 == K_UTR || k2 == K_UTRPART || k2 == K_EXON || k2 == K_EXONPART) begin
				if (f1.lo > f2.lo + m && f1.hi < f2.hi - m) return 0;
				if (s == S_PLUS && ((k1 == K_TSS && f1.lo > f2.lo + m) ||
					(k1 == K_TTS && f1.hi < f2.hi - m))) return 0;
				if (s == S_MINUS && ((k1 == K_TSS && f1.hi < f2.hi - m) ||
					(k1 == K_TTS && f1.lo > f2.lo + m))) return 0;
			end
			return 1;
		end
		if (k1 == K_EXONPART) begin
			if (k2 == K_INTRONPART || k2 == K_INTRON || k2 == K_IRPART ||
				k2 == K_NONEXONPART) return 0;
			if (k2 == K_EXON && (f1.lo < f2.lo || f1.hi > f2.hi)) return 0;
			if (k2 == K_UTR && f1.lo < f2.lo && f1.hi > f2.hi) return 0;
			return 1;
		end
		if (k1 == K_EXON) begin
			if (k2 == K_INTRONPART || k2 == K_INTRON || k2 == K_IRPART ||
				k2 == K_NONEXONPART) return 0;
			if (k2 == K_CDS && !(f1.lo <= f2.lo && f1.hi >= f2.hi)) return 0;
			if (k2 == K_CDSPART && (f1.lo > f2.lo || f1.hi < f2.hi)) return 0;
			if (k2 == K_UTR && !((f1.lo == f2.lo && f1.hi >= f2.hi) ||
				(f1.hi == f2.hi && f1.lo <= f2.hi))) return 0;
			if (k2 == K_UTRPART && (f1.lo > f2.lo || f1.hi < f2.hi)) return 0;
			return 1;
		end
		if (k1 == K_INTRONPART || k1 == K_INTRON) begin
			if (k1 == K_INTRONPART && k2 == K_INTRON && (f1.lo < f2.lo || f1.hi > f2.hi))
				return 0;
			return !(k2 == K_IRPART || k2 == K_CDS || k2 == K_CDSPART ||
				k2 == K_UTR || k2 == K_UTRPART);
		end
		if (k1 == K_IRPART) return k2 == K_NONEXONPART;
		if (k1 == K_CDS) return k2 == K_CDSPART && f1.lo <= f2.lo && f1.hi >= f2.hi;
		if (k1 == K_UTR) return k2 == K_UTRPART && f1.lo <= f2.lo && f1.hi >= f2.hi;
		return 0;
	endfunction

	// Weaker test; strict flag returned through ref.
	function automatic bit first_weaker(pair_hint_t a, pair_hint_t b, ref bit strict);
		logic [4:0] ka, kb;
		bit inb;
		ka = a.kind;
		kb = b.kind;
		inb = inside_of(a, b);
		strict = 0;
		if (b.hi < a.lo || b.lo > a.hi) return 0;
		if (ka == kb && a.lo == b.lo && a.hi == b.hi) return 1;
		strict = (a.lo != b.lo || a.hi != b.hi);
		if (ka == kb && is_sig(ka) && a.lo <= b.lo && a.hi >= b.hi) return 1;
		if (!inb) return 0;
		if (ka == K_EXONPART && (kb == K_EXON || kb == K_EXONPART)) return 1;
		if (ka == K_INTRONPART && (kb == K_INTRON || kb == K_INTRONPART)) return 1;
		if (ka == K_IRPART && kb == K_IRPART) return 1;
		if (ka == K_CDSPART && (kb == K_CDS || kb == K_CDSPART)) return 1;
		if (ka == K_UTRPART && (kb == K_UTR || kb == K_UTRPART)) return 1;
		if (ka == K_NONEXONPART && kb == K_NONEXONPART) return 1;
		if (ka == K_GENICPART && kb != K_IRPART) return 1;
		return 0;
	endfunction

	function automatic res_t judge_pair(logic [143:0] d);
		pair_hint_t a, b;
		res_t r;
		bit strict, w;
		a = unpack_hint(d[70:0]);
		b = unpack_hint(d[141:71]);
		w = first_weaker(a, b, strict);
		r.compatible = pair_compatible(a, b);
		r.a_weaker = w;
		r.strictly_weaker = w & strict;
		return r;
	endfunction

	function automatic logic [143:0] pack_pair(logic [4:0] ka, logic [31:0] la,
		logic [31:0] ha, logic [1:0] sa, logic [4:0] kb, logic [31:0] lb,
		logic [31:0] hb, logic [1:0] sb);
		return {2'b00, sb, hb, lb, kb, sa, ha, la, ka};
	endfunction

	// Random coordinate: mostly a small window so overlaps and margins matter.
	function automatic logic [31:0] rand_coord(logic [31:0] base);
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'h8000_0000 + $urandom_range(3);
			2: return 32'h7FFF_FFFF - $urandom_range(3);
			default: return base + $urandom_range(1200) - 600;
		endcase
	endfunction

	function automatic logic [143:0] rand_pair();
		logic [31:0] base, la, ha, lb, hb;
		logic [4:0] ka, kb;
		base = $urandom();
		la = rand_coord(base);
		// Keep most intervals forward, a few reversed.
		ha = ($urandom_range(9) == 0) ? rand_coord(base) : la + $urandom_range(400);
		case ($urandom_range(3))
			0: begin lb = la; hb = ha; end
			1: begin lb = la + $urandom_range(60); hb = ha - $urandom_range(60); end
			default: begin lb = rand_coord(base); hb = lb + $urandom_range(400); end
		endcase
		ka = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
		kb = ($urandom_range(3) == 0) ? ka :
			(($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16)));
		return pack_pair(ka, la, ha, 2'($urandom_range(3)), kb, lb, hb,
			2'($urandom_range(3)));
	endfunction

	// Sender: bursts of random length with random gaps.
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			verdicts_due = {verdicts_due, judge_pair(s_axis_tdata)};
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0 || pending_pairs.size() == 0) begin
				s_axis_tvalid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_pairs.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(40, 1);
					gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: stall pattern runs in phases of random duty.
	int stall_phase = 0, stall_mode = 0;
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode <= $urandom_range(3);
			stall_phase <= $urandom_range(60, 5);
		end else begin
			stall_phase <= stall_phase - 1;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(1);
			2: m_axis_tready <= ($urandom_range(4) == 0);
			default: m_axis_tready <= (stall_phase[2] == 1'b0);
		endcase
	end

	// Monitor: compare each verdict with the oldest expectation.
	always @(posedge clk) begin
		res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.compatible = m_axis_tdata[0];
			got.a_weaker = m_axis_tdata[1];
			got.strictly_weaker = m_axis_tdata[2];
			if (verdicts_due.size() == 0) begin
				$error("verdict with no pair outstanding: %b", m_axis_tdata);
				fails++;
			end else begin
				want = verdicts_due.pop_front();
				if (got.compatible !== want.compatible) begin
					$error("compatible: expected %b actual %b", want.compatible, got.compatible);
					fails++;
				end
				if (got.a_weaker !== want.a_weaker) begin
					$error("a_weaker: expected %b actual %b", want.a_weaker, got.a_weaker);
					fails++;
				end
				if (got.strictly_weaker !== want.strictly_weaker) begin
					$error("strictly_weaker: expected %b actual %b",
						want.strictly_weaker, got.strictly_weaker);
					fails++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TSS_CLOSE[1:0]: tss_dist = val;
			REG_TTS_CLOSE[1:0]: tts_dist = val;
			default: margin = val;
		endcase
	endtask

	// Hold until the pipeline has drained.
	task automatic drain();
		wait (pending_pairs.size() == 0 && !s_axis_tvalid && verdicts_due.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_directed();
		// Extremes of coordinates, some kinds paired with signal kinds, reversed
		// intervals, strand three, kinds above sixteen.
		queue_pair(pack_pair(K_TSS, 0, 10, S_PLUS, K_TSS, 12, 20, S_PLUS));
		queue_pair(pack_pair(K_TTS, 0, 10, S_MINUS, K_TTS, 500, 600, S_MINUS));
		queue_pair(pack_pair(K_START, 32'h8000_0000, 32'h8000_0000, 2'd3,
			K_CDS, 32'h8000_0000, 32'h7FFF_FFFF, 2'd3));
		queue_pair(pack_pair(K_STOP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, S_PLUS,
			K_CDS, 32'h8000_0000, 32'h7FFF_FFFF, S_PLUS));
		queue_pair(pack_pair(5'd31, 5, 9, 2'd2, 5'd17, 5, 9, 2'd2));
		queue_pair(pack_pair(5'd20, 5, 9, 2'd3, 5'd20, 6, 8, 2'd3));
		queue_pair(pack_pair(K_EXON, 100, 50, S_PLUS, K_UTR, 100, 50, S_PLUS));
		queue_pair(pack_pair(K_GENICPART, 10, 20, S_MINUS,
			K_EXON, 0, 30, S_MINUS));
		queue_pair(pack_pair(K_ASS, 15, 15, S_MINUS, K_INTRON, 10, 20, S_MINUS));
		queue_pair(pack_pair(K_DSS, 10, 10, S_PLUS, K_INTRONPART, 10, 20,
			S_PLUS));
		queue_pair(pack_pair(K_EXON, 0, 100, S_PLUS, K_TSS, 60, 60, S_MINUS));
		queue_pair(pack_pair(K_UTR, 0, 100, S_MINUS, K_TTS, 70, 70, S_MINUS));
		queue_pair(pack_pair(K_CDSPART, 10, 20, S_PLUS, K_CDS, 0, 30, S_PLUS));
		queue_pair(pack_pair(K_UTRPART, 10, 20, S_PLUS, K_UTR, 0, 30, S_PLUS));
		queue_pair(pack_pair(K_NONEXONPART, 10, 20, S_PLUS,
			K_IRPART, 0, 30, S_PLUS));
		queue_pair(pack_pair(K_START, 5, 5, S_PLUS, K_START, 4, 6, S_PLUS));
		queue_pair(pack_pair(5'h1F, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 2'd3,
			5'h1F, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 2'd3));
	endtask

	initial begin
		int phase;
		tss_dist = TSS_CLOSE_RST;
		tts_dist = TTS_CLOSE_RST;
		margin = MARGIN_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		load_directed();
		drain();
		// Walk register settings, extremes included.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_TSS_CLOSE[1:0], 16'hFFFF);
					write_reg(REG_TTS_CLOSE[1:0], 16'd0); write_reg(REG_MARGIN[1:0], 16'd0); end
				1: begin write_reg(REG_TSS_CLOSE[1:0], 16'd300);
					write_reg(REG_TTS_CLOSE[1:0], 16'hFFFF); write_reg(REG_MARGIN[1:0], 16'hFFFF); end
				default: begin write_reg(REG_TSS_CLOSE[1:0], 16'($urandom_range(800)));
					write_reg(REG_TTS_CLOSE[1:0], 16'($urandom_range(800)));
					write_reg(REG_MARGIN[1:0], 16'($urandom_range(200))); end
			endcase
			if (phase < 2) load_directed();
			repeat (210) queue_pair(rand_pair());
			drain();
		end
		repeat (10) @(posedge clk);
		if (fails == 0 && verdicts_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
rtl/ghpc_pkg.sv
rtl/ghpc_cmp.sv
rtl/ghpc_rule.sv
rtl/gene_hint_pair_compatibility.sv
rtl/ghpc_checker.sv
verif/gene_hint_pair_compatibility_tb.sv
